### hdl/swiq_pkg.sv
// Shared types and constants for the square-wave I/Q synchronous detector.
// No dependencies; imported by every module of the block.
package swiq_pkg;

    localparam int CH_W   = 3;   // channel field
    localparam int RD_W   = 16;  // converter reading
    localparam int ACC_W  = 23;  // accumulator width, sums wrap at 2^23
    localparam int AVG_W  = 18;  // reported average width
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    // Quadrature phase codes, stepped in Gray order 00, 01, 11, 10
    typedef enum logic [1:0] {
        PH_00 = 2'b00,
        PH_01 = 2'b01,
        PH_11 = 2'b11,
        PH_10 = 2'b10
    } quad_phase_t;

    // Control for one accumulator read-modify-write
    typedef struct packed {
        logic upd;    // write the entry back
        logic clear;  // start from zero instead of the stored sums
        logic i_sub;  // subtract the reading from I
        logic q_sub;  // subtract the reading from Q
    } acc_ctrl_t;

    function automatic quad_phase_t phase_step(input quad_phase_t ph);
        quad_phase_t nxt;
        case (ph)
            PH_00:   nxt = PH_01;
            PH_01:   nxt = PH_11;
            PH_11:   nxt = PH_10;
            PH_10:   nxt = PH_00;
            default: nxt = PH_00;
        endcase
        return nxt;
    endfunction

endpackage

### hdl/swiq_acc_bank.sv
// Per-channel DC, I and Q accumulators with a read-modify-write: combinational read, registered write.
// Depends on swiq_pkg for widths and the acc_ctrl_t control struct.
module swiq_acc_bank
    import swiq_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  acc_ctrl_t                                  ctrl,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] idx,
    input  logic [RD_W-1:0]                            reading,
    output logic [ACC_W-1:0]                           dc_old,
    output logic signed [ACC_W-1:0]                    i_old,
    output logic signed [ACC_W-1:0]                    q_old
);

    logic [ACC_W-1:0] dc_reg [CHANNELS];
    logic [ACC_W-1:0] i_reg  [CHANNELS];
    logic [ACC_W-1:0] q_reg  [CHANNELS];

    logic [ACC_W-1:0] dc_base;
    logic [ACC_W-1:0] i_base;
    logic [ACC_W-1:0] q_base;
    logic [ACC_W-1:0] rd_ext;
    logic [ACC_W-1:0] dc_next;
    logic [ACC_W-1:0] i_next;
    logic [ACC_W-1:0] q_next;

    assign dc_old = dc_reg[idx];
    assign i_old  = i_reg[idx];
    assign q_old  = q_reg[idx];

    always_comb
    begin
        rd_ext  = ACC_W'(reading);
        dc_base = ctrl.clear ? '0 : dc_reg[idx];
        i_base  = ctrl.clear ? '0 : i_reg[idx];
        q_base  = ctrl.clear ? '0 : q_reg[idx];
        dc_next = dc_base + rd_ext;
        i_next  = ctrl.i_sub ? (i_base - rd_ext) : (i_base + rd_ext);
        q_next  = ctrl.q_sub ? (q_base - rd_ext) : (q_base + rd_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                dc_reg[c] <= '0;
                i_reg[c]  <= '0;
                q_reg[c]  <= '0;
            end
        end
        else if (ctrl.upd)
        begin
            dc_reg[idx] <= dc_next;
            i_reg[idx]  <= i_next;
            q_reg[idx]  <= q_next;
        end
    end

endmodule

### hdl/swiq_recip_div.sv
// Exact unsigned divide of an accumulator magnitude by QUARTER_LEN,
// done as a multiply by a rounded-up reciprocal and a shift. Uses swiq_pkg.
module swiq_recip_div
    import swiq_pkg::*;
#(
    parameter int QUARTER_LEN = 16
) (
    input  logic [ACC_W-1:0] dividend,
    output logic [ACC_W-1:0] quotient
);

    localparam int SHIFT  = ACC_W + $clog2(QUARTER_LEN);
    localparam int MULT_W = ACC_W + 2;
    localparam int PROD_W = ACC_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT =
        MULT_W'(((64'd1 << SHIFT) + 64'(QUARTER_LEN) - 64'd1) / 64'(QUARTER_LEN));

    logic [PROD_W-1:0] prod;

    assign prod     = PROD_W'(dividend) * PROD_W'(MULT);
    assign quotient = ACC_W'(prod >> SHIFT);

endmodule

### hdl/square_wave_iq_sync_detector.sv
// Square-wave I/Q synchronous detector (lock-in with square reference).
// Uses swiq_pkg, swiq_acc_bank and swiq_recip_div.
//
// Usage:
//   Input stream s_axis carries one reading per transfer; a scan is channels
//   0..CHANNELS-1 in order. Channel 0 advances the sample counter; each wrap
//   at QUARTER_LEN steps the quadrature phase 00, 01, 11, 10. Channels at or
//   above CHANNELS are dropped without touching any state.
//   Output stream m_axis carries one report per channel at the start of each
//   full reference period (counter and phase both back at zero): DC, I and Q
//   sums of the finished period divided by QUARTER_LEN, truncated toward zero.
//   Throughput: one transfer per cycle while the output is not stalled. Each item
//   passes an input register, a report register (accumulator read-modify-write)
//   and the output register (reciprocal multiply) on its way to m_axis.
//   Stall: while m_axis holds a report that is not taken, the pipeline holds
//   and s_axis_tready is low.
//   Reset: counter, phase and all sums clear at once; the first report comes
//   after 4*QUARTER_LEN scans.
module square_wave_iq_sync_detector
    import swiq_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int QUARTER_LEN = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] channel, [18:3] reading, [23:19] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] out_channel, [20:3] dc_average, [38:21] i_average,
    // [56:39] q_average, [63:57] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(QUARTER_LEN);

    logic advance;

    // input stage
    logic            in_valid_reg;
    logic [CH_W-1:0] in_ch_reg;
    logic [RD_W-1:0] in_rd_reg;

    // sequencing state
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    quad_phase_t      phase_reg;
    quad_phase_t      phase_next;

    logic      in_range;
    logic      emit;
    acc_ctrl_t acc_ctrl;

    logic [ACC_W-1:0]        dc_old;
    logic signed [ACC_W-1:0] i_old;
    logic signed [ACC_W-1:0] q_old;

    // report stage
    logic                    rep_valid_reg;
    logic [CH_W-1:0]         rep_ch_reg;
    logic [ACC_W-1:0]        rep_dc_reg;
    logic signed [ACC_W-1:0] rep_i_reg;
    logic signed [ACC_W-1:0] rep_q_reg;

    logic [ACC_W-1:0] i_mag;
    logic [ACC_W-1:0] q_mag;
    logic [ACC_W-1:0] dc_quo;
    logic [ACC_W-1:0] i_quo;
    logic [ACC_W-1:0] q_quo;
    logic [AVG_W-1:0] dc_avg;
    logic [AVG_W-1:0] i_avg;
    logic [AVG_W-1:0] q_avg;

    // output stage
    logic             out_valid_reg;
    logic [CH_W-1:0]  out_ch_reg;
    logic [AVG_W-1:0] out_dc_reg;
    logic [AVG_W-1:0] out_i_reg;
    logic [AVG_W-1:0] out_q_reg;

    // hold every stage while a report waits on the output
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_axis_tvalid)
        begin
            in_ch_reg <= s_axis_tdata[CH_W-1:0];
            in_rd_reg <= s_axis_tdata[CH_W+RD_W-1:CH_W];
        end
    end

    always_comb
    begin
        in_range   = int'(in_ch_reg) < CHANNELS;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (in_ch_reg == '0)
        begin
            if (cnt_reg == CNT_W'(QUARTER_LEN - 1))
            begin
                cnt_next   = '0;
                phase_next = phase_step(phase_reg);
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        emit           = in_range && (cnt_next == '0) && (phase_next == PH_00);
        acc_ctrl.upd   = advance && in_valid_reg && in_range;
        acc_ctrl.clear = emit;
        acc_ctrl.i_sub = phase_next[1];
        acc_ctrl.q_sub = phase_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= PH_00;
        end
        else if (acc_ctrl.upd)
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    swiq_acc_bank #(
        .CHANNELS (CHANNELS)
    ) u_acc_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (acc_ctrl),
        .idx     (IDX_W'(in_ch_reg)),
        .reading (in_rd_reg),
        .dc_old  (dc_old),
        .i_old   (i_old),
        .q_old   (q_old)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rep_valid_reg <= 1'b0;
        else if (advance)
            rep_valid_reg <= in_valid_reg && emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && emit)
        begin
            rep_ch_reg <= in_ch_reg;
            rep_dc_reg <= dc_old;
            rep_i_reg  <= i_old;
            rep_q_reg  <= q_old;
        end
    end

    // divide magnitudes, then restore the sign: truncates toward zero
    assign i_mag = rep_i_reg[ACC_W-1] ? (ACC_W'(0) - rep_i_reg) : rep_i_reg;
    assign q_mag = rep_q_reg[ACC_W-1] ? (ACC_W'(0) - rep_q_reg) : rep_q_reg;

    swiq_recip_div #(.QUARTER_LEN(QUARTER_LEN)) u_div_dc (.dividend(rep_dc_reg), .quotient(dc_quo));
    swiq_recip_div #(.QUARTER_LEN(QUARTER_LEN)) u_div_i  (.dividend(i_mag),      .quotient(i_quo));
    swiq_recip_div #(.QUARTER_LEN(QUARTER_LEN)) u_div_q  (.dividend(q_mag),      .quotient(q_quo));

    always_comb
    begin
        dc_avg = dc_quo[AVG_W-1:0];
        i_avg  = rep_i_reg[ACC_W-1] ? (AVG_W'(0) - i_quo[AVG_W-1:0]) : i_quo[AVG_W-1:0];
        q_avg  = rep_q_reg[ACC_W-1] ? (AVG_W'(0) - q_quo[AVG_W-1:0]) : q_quo[AVG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= rep_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && rep_valid_reg)
        begin
            out_ch_reg <= rep_ch_reg;
            out_dc_reg <= dc_avg;
            out_i_reg  <= i_avg;
            out_q_reg  <= q_avg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - CH_W - 3 * AVG_W)'(0),
                            out_q_reg, out_i_reg, out_dc_reg, out_ch_reg};

endmodule

### hdl/swiq_checker.sv
// Port-level checks for the square-wave I/Q synchronous detector, bound to
// the top level. Depends on swiq_pkg for field widths.
module swiq_checker
    import swiq_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int USED_W = CH_W + 3 * AVG_W;

    // a report not taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("report changed while stalled");

    // a stalled output blocks the input side
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:USED_W] == '0)
        else $error("output padding not zero");

    // only channels that exist are reported
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> int'(m_axis_tdata[CH_W-1:0]) < CHANNELS)
        else $error("report for a channel beyond CHANNELS");

endmodule

bind square_wave_iq_sync_detector swiq_checker #(
    .CHANNELS (CHANNELS)
) u_swiq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
